FILE: sv/barsl_pkg.sv
// Shared constants, types and helpers of the bit array run slicer.
package barsl_pkg;

	localparam int MAX_BITS   = 2048;
	localparam int WORD_BITS  = 64;
	localparam int WORD_SH    = $clog2(WORD_BITS);
	localparam int MEM_DEPTH  = MAX_BITS / WORD_BITS;
	localparam int WORD_IDX_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int WCNT_W     = WORD_IDX_W + 1;
	localparam int LEN_W      = $clog2(MAX_BITS + 1);
	localparam int COUNT_W    = 12;

	localparam logic [2:0] BIT_FALSE = 3'd0;
	localparam logic [2:0] BIT_TRUE  = 3'd1;
	localparam logic [2:0] BIT_POS   = 3'd2;
	localparam logic [2:0] BIT_NEG   = 3'd3;

	localparam logic [1:0] SLICE_REPEAT  = 2'd0;
	localparam logic [1:0] SLICE_EXTRACT = 2'd1;
	localparam logic [1:0] SLICE_WORD    = 2'd2;
	localparam logic [1:0] SLICE_FAIL    = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         rbit;
		logic [29:0]        vec;
		logic [15:0]        lo;
		logic [15:0]        hi;
		logic [COUNT_W-1:0] cnt;
	} res_t;

	typedef struct packed {
		logic              a_drain;
		res_t              a;
		logic [WCNT_W-1:0] words;
		logic              b_valid;
		res_t              b;
		logic              mark;
	} plan_t;

	function automatic res_t make_res(input logic [1:0] kind, input logic [1:0] rbit,
			input logic [29:0] vec, input logic [15:0] lo, input logic [15:0] hi,
			input logic [COUNT_W-1:0] cnt);
		res_t r;
		r.kind = kind;
		r.rbit = rbit;
		r.vec  = vec;
		r.lo   = lo;
		r.hi   = hi;
		r.cnt  = cnt;
		return r;
	endfunction

	function automatic logic [WCNT_W-1:0] word_count(input logic [LEN_W-1:0] len);
		logic [LEN_W:0] sum;
		sum = {1'b0, len} + (LEN_W + 1)'(WORD_BITS - 1);
		return WCNT_W'(sum >> WORD_SH);
	endfunction

endpackage

FILE: sv/barsl_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module barsl_ram #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/barsl_slicer.sv
// Run tracker: classifies each bit, fills the constant word store and plans results.
module barsl_slicer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [2:0]                          bit_kind,
	input  logic [29:0]                         vector_id,
	input  logic [15:0]                         bit_index,
	input  logic                                last_bit,
	output barsl_pkg::plan_t                    plan,
	output logic                                plan_load,
	output logic                                wr_en,
	output logic [barsl_pkg::WORD_IDX_W-1:0]    wr_addr,
	output logic [barsl_pkg::WORD_BITS-1:0]     wr_data
);
	import barsl_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE, M_CONST, M_PEND, M_REPEAT, M_EXTRACT, M_DISCARD
	} mode_t;

	mode_t                mode_q, n_mode;
	logic [1:0]           kind_q, n_kind;
	logic [29:0]          vec_q, n_vec;
	logic [15:0]          idx_q, n_idx;
	logic [LEN_W-1:0]     len_q, n_len;
	logic [LEN_W-1:0]     total_q, n_total;
	logic                 same_q, n_same;
	logic                 first_q, n_first;
	logic [WORD_BITS-1:0] acc_q, acc_base, acc_new;

	logic             is_const, is_sel, same;
	logic             have_a, absorbed, failed;
	logic             add_en, add_bit;
	logic [LEN_W-1:0] add_pos;
	res_t             r;

	assign is_const = (bit_kind == BIT_FALSE) || (bit_kind == BIT_TRUE);
	assign is_sel   = (bit_kind == BIT_POS) || (bit_kind == BIT_NEG);
	assign same     = is_sel && (bit_kind[1:0] == kind_q) && (vector_id == vec_q)
			&& (bit_index == idx_q);

	always_comb begin
		n_mode   = mode_q;
		n_kind   = kind_q;
		n_vec    = vec_q;
		n_idx    = idx_q;
		n_len    = len_q;
		n_total  = total_q;
		n_same   = same_q;
		n_first  = first_q;
		plan     = '0;
		r        = '0;
		have_a   = 1'b0;
		absorbed = 1'b0;
		failed   = 1'b0;
		add_en   = 1'b0;
		add_bit  = 1'b0;
		add_pos  = '0;
		if (mode_q == M_DISCARD) begin
			if (last_bit) begin
				n_mode  = M_IDLE;
				n_len   = '0;
				n_total = '0;
			end
		end else begin
			if (total_q >= LEN_W'(MAX_BITS)) begin
				failed = 1'b1;
			end else begin
				n_total = total_q + LEN_W'(1);
				case (mode_q)
					M_CONST: begin
						if (is_const) begin
							add_en   = 1'b1;
							add_pos  = len_q;
							add_bit  = bit_kind[0];
							n_len    = len_q + LEN_W'(1);
							n_same   = same_q && (bit_kind[0] == first_q);
							absorbed = 1'b1;
						end else begin
							if (same_q) begin
								plan.a = make_res(SLICE_REPEAT, {1'b0, first_q}, '0, '0, '0,
										COUNT_W'(len_q));
							end else begin
								plan.a_drain = 1'b1;
								plan.a = make_res(SLICE_WORD, '0, '0, '0, '0, COUNT_W'(len_q));
								plan.words = word_count(len_q);
							end
							have_a = 1'b1;
						end
					end
					M_PEND: begin
						if (same) begin
							n_mode   = M_REPEAT;
							n_len    = LEN_W'(2);
							absorbed = 1'b1;
						end else if ((kind_q == BIT_POS[1:0]) && (bit_kind == BIT_POS)
								&& (vector_id == vec_q)
								&& ({1'b0, bit_index} == {1'b0, idx_q} + 17'd1)) begin
							n_mode   = M_EXTRACT;
							n_len    = LEN_W'(2);
							absorbed = 1'b1;
						end else begin
							failed = 1'b1;
						end
					end
					M_REPEAT: begin
						if (same) begin
							n_len    = len_q + LEN_W'(1);
							absorbed = 1'b1;
						end else begin
							plan.a = make_res(SLICE_REPEAT, kind_q, vec_q, idx_q, '0,
									COUNT_W'(len_q));
							have_a = 1'b1;
						end
					end
					M_EXTRACT: begin
						if ((bit_kind == BIT_POS) && (vector_id == vec_q)
								&& ({1'b0, bit_index} == {1'b0, idx_q} + 17'(len_q))) begin
							n_len    = len_q + LEN_W'(1);
							absorbed = 1'b1;
						end else begin
							plan.a = make_res(SLICE_EXTRACT, '0, vec_q, idx_q,
									idx_q + 16'(len_q) - 16'd1, '0);
							have_a = 1'b1;
						end
					end
					default: begin
					end
				endcase

				if (!failed && !absorbed) begin
					if (is_const) begin
						n_mode  = M_CONST;
						add_en  = 1'b1;
						add_pos = '0;
						add_bit = bit_kind[0];
						n_len   = LEN_W'(1);
						n_same  = 1'b1;
						n_first = bit_kind[0];
					end else if (is_sel) begin
						n_mode = M_PEND;
						n_kind = bit_kind[1:0];
						n_vec  = vector_id;
						n_idx  = bit_index;
						n_len  = LEN_W'(1);
					end else begin
						failed = 1'b1;
					end
				end

				if (!failed && last_bit) begin
					case (n_mode)
						M_CONST: begin
							if (n_same) begin
								r = make_res(SLICE_REPEAT, {1'b0, n_first}, '0, '0, '0,
										COUNT_W'(n_len));
								if (have_a) begin
									plan.b       = r;
									plan.b_valid = 1'b1;
								end else begin
									plan.a = r;
								end
							end else begin
								plan.a_drain = 1'b1;
								plan.a = make_res(SLICE_WORD, '0, '0, '0, '0, COUNT_W'(n_len));
								plan.words = word_count(n_len);
							end
							have_a = 1'b1;
						end
						M_PEND: begin
							failed = 1'b1;
						end
						M_REPEAT: begin
							r = make_res(SLICE_REPEAT, n_kind, n_vec, n_idx, '0, COUNT_W'(n_len));
							if (have_a) begin
								plan.b       = r;
								plan.b_valid = 1'b1;
							end else begin
								plan.a = r;
							end
							have_a = 1'b1;
						end
						M_EXTRACT: begin
							r = make_res(SLICE_EXTRACT, '0, n_vec, n_idx,
									n_idx + 16'(n_len) - 16'd1, '0);
							if (have_a) begin
								plan.b       = r;
								plan.b_valid = 1'b1;
							end else begin
								plan.a = r;
							end
							have_a = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end

			if (failed) begin
				r = make_res(SLICE_FAIL, '0, '0, '0, '0, '0);
				if (have_a) begin
					plan.b       = r;
					plan.b_valid = 1'b1;
				end else begin
					plan.a = r;
				end
				have_a = 1'b1;
				if (last_bit) begin
					n_mode  = M_IDLE;
					n_len   = '0;
					n_total = '0;
				end else begin
					n_mode = M_DISCARD;
				end
			end else if (last_bit) begin
				n_mode  = M_IDLE;
				n_len   = '0;
				n_total = '0;
			end
			plan.mark = failed || last_bit;
		end
	end

	assign acc_base  = (add_pos[WORD_SH-1:0] == '0) ? '0 : acc_q;
	assign acc_new   = acc_base | (WORD_BITS'(add_bit) << add_pos[WORD_SH-1:0]);
	assign wr_en     = take && add_en;
	assign wr_addr   = WORD_IDX_W'(add_pos >> WORD_SH);
	assign wr_data   = acc_new;
	assign plan_load = take && have_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			kind_q  <= '0;
			vec_q   <= '0;
			idx_q   <= '0;
			len_q   <= '0;
			total_q <= '0;
			same_q  <= 1'b1;
			first_q <= 1'b0;
			acc_q   <= '0;
		end else if (take) begin
			mode_q  <= n_mode;
			kind_q  <= n_kind;
			vec_q   <= n_vec;
			idx_q   <= n_idx;
			len_q   <= n_len;
			total_q <= n_total;
			same_q  <= n_same;
			first_q <= n_first;
			if (add_en) begin
				acc_q <= acc_new;
			end
		end
	end

endmodule

FILE: sv/barsl_emit.sv
// Result sequencer: steps through a planned item's results into the output register.
module barsl_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  barsl_pkg::plan_t                   plan,
	input  logic                               plan_load,
	output logic                               plan_ready,
	output logic                               rd_en,
	output logic [barsl_pkg::WORD_IDX_W-1:0]   rd_addr,
	input  logic [barsl_pkg::WORD_BITS-1:0]    rd_data,
	output logic                               slice_valid,
	input  logic                               slice_stall,
	output logic [1:0]                         slice_kind,
	output logic [1:0]                         repeat_bit,
	output logic [29:0]                        source_vector,
	output logic [15:0]                        low_index,
	output logic [15:0]                        high_index,
	output logic [11:0]                        bit_count,
	output logic [63:0]                        const_word,
	output logic                               word_last,
	output logic                               array_last
);
	import barsl_pkg::*;

	typedef enum logic {P_FIRST, P_SECOND} phase_t;

	phase_t            phase_q;
	plan_t             plan_q;
	logic              busy_q;
	logic [WCNT_W-1:0] ptr_q;
	res_t              out_q;
	logic              valid_q, word_q, wlast_q, alast_q;

	logic drain_now, last_word, final_res, out_load;
	res_t cur;

	assign drain_now  = (phase_q == P_FIRST) && plan_q.a_drain;
	assign last_word  = (ptr_q + WCNT_W'(1)) == plan_q.words;
	assign cur        = (phase_q == P_SECOND) ? plan_q.b : plan_q.a;
	assign final_res  = (phase_q == P_SECOND)
			|| (!plan_q.b_valid && (!plan_q.a_drain || last_word));
	assign out_load   = busy_q && (!valid_q || !slice_stall);
	assign plan_ready = !busy_q || (out_load && final_res);
	assign rd_en      = out_load && drain_now;
	assign rd_addr    = ptr_q[WORD_IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_FIRST;
			plan_q  <= '0;
			busy_q  <= 1'b0;
			ptr_q   <= '0;
			out_q   <= '0;
			valid_q <= 1'b0;
			word_q  <= 1'b0;
			wlast_q <= 1'b0;
			alast_q <= 1'b0;
		end else begin
			if (out_load) begin
				valid_q <= 1'b1;
				out_q   <= cur;
				word_q  <= drain_now;
				wlast_q <= drain_now && last_word;
				alast_q <= final_res && plan_q.mark;
			end else if (!slice_stall) begin
				valid_q <= 1'b0;
			end

			if (plan_load) begin
				plan_q  <= plan;
				busy_q  <= 1'b1;
				phase_q <= P_FIRST;
				ptr_q   <= '0;
			end else if (out_load) begin
				if (final_res) begin
					busy_q <= 1'b0;
				end else if (drain_now && !last_word) begin
					ptr_q <= ptr_q + WCNT_W'(1);
				end else begin
					phase_q <= P_SECOND;
				end
			end
		end
	end

	assign slice_valid   = valid_q;
	assign slice_kind    = out_q.kind;
	assign repeat_bit    = out_q.rbit;
	assign source_vector = out_q.vec;
	assign low_index     = out_q.lo;
	assign high_index    = out_q.hi;
	assign bit_count     = out_q.cnt;
	assign const_word    = word_q ? rd_data : '0;
	assign word_last     = wlast_q;
	assign array_last    = alast_q;

endmodule

FILE: sv/bit_array_run_slicer.sv
// Top level of the bit array run slicer.
//
// Bits of an array arrive least significant first on the bit channel
// (bit_valid, bit_stall), one item per cycle while bit_stall is low; last_bit
// marks the array's final bit. Slices leave on the slice channel (slice_valid,
// slice_stall); array_last marks the final result of an array and a failure
// result always carries it. An item's plan is registered in the emitter, and
// its first result then in the output register. Items that yield no result
// or a single result stream at one per cycle while the receiver does not
// stall; each further result of the same item holds the bit channel. A
// constant slice is read back from the word store one word per cycle while
// the receiver does not stall. The word store has one write and one read
// port, and the bit channel waits while a constant slice is being read out.
// After reset no array is in progress and the next bit starts a new array.
// When the receiver stalls, the output register and one planned item hold,
// and bit_stall rises once that planned item cannot complete.
module bit_array_run_slicer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        bit_valid,
	output logic        bit_stall,
	input  logic [2:0]  bit_kind,
	input  logic [29:0] vector_id,
	input  logic [15:0] bit_index,
	input  logic        last_bit,
	output logic        slice_valid,
	input  logic        slice_stall,
	output logic [1:0]  slice_kind,
	output logic [1:0]  repeat_bit,
	output logic [29:0] source_vector,
	output logic [15:0] low_index,
	output logic [15:0] high_index,
	output logic [11:0] bit_count,
	output logic [63:0] const_word,
	output logic        word_last,
	output logic        array_last
);
	import barsl_pkg::*;

	plan_t                 plan;
	logic                  plan_load, plan_ready, take;
	logic                  wr_en, rd_en;
	logic [WORD_IDX_W-1:0] wr_addr, rd_addr;
	logic [WORD_BITS-1:0]  wr_data, rd_data;

	assign take      = bit_valid && plan_ready;
	assign bit_stall = !plan_ready;

	barsl_slicer u_slicer (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.bit_kind  (bit_kind),
		.vector_id (vector_id),
		.bit_index (bit_index),
		.last_bit  (last_bit),
		.plan      (plan),
		.plan_load (plan_load),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	barsl_ram #(
		.DATA_W (WORD_BITS),
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (WORD_IDX_W)
	) u_words (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	barsl_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.plan          (plan),
		.plan_load     (plan_load),
		.plan_ready    (plan_ready),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.slice_valid   (slice_valid),
		.slice_stall   (slice_stall),
		.slice_kind    (slice_kind),
		.repeat_bit    (repeat_bit),
		.source_vector (source_vector),
		.low_index     (low_index),
		.high_index    (high_index),
		.bit_count     (bit_count),
		.const_word    (const_word),
		.word_last     (word_last),
		.array_last    (array_last)
	);

endmodule

FILE: bench/bit_array_run_slicer_test.sv
// Self-checking testbench of the bit array run slicer: directed rows, long arrays and random arrays.
`timescale 1ns / 100ps

module bit_array_run_slicer_test;
	import barsl_pkg::*;

	localparam logic [2:0] KIND_OTHER_LO = 3'd4;
	localparam logic [2:0] KIND_OTHER_HI = 3'd7;
	localparam int RANDOM_ITEMS = 410;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum logic [2:0] {
		M_IDLE, M_CONST, M_PEND, M_REPEAT, M_EXTRACT, M_DISCARD
	} slicer_mode_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  rbit;
		logic [29:0] vec;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [11:0] cnt;
		logic [63:0] word;
		logic        wlast;
		logic        alast;
	} slice_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [29:0] vec;
		logic [15:0] idx;
		logic        last;
	} bit_item_t;

	typedef struct packed {
		bit_item_t item;
		logic      typed;
		slice_t    res;
	} stim_row_t;

	localparam slice_t NO_SLICE = '0;
	localparam slice_t FAIL_SLICE = '{kind: SLICE_FAIL, alast: 1'b1, default: '0};
	localparam slice_t ONE_TRUE_SLICE = '{kind: SLICE_REPEAT, rbit: 2'(BIT_TRUE),
		cnt: 12'd1, alast: 1'b1, default: '0};
	localparam slice_t ONE_FALSE_SLICE = '{kind: SLICE_REPEAT, rbit: 2'(BIT_FALSE),
		cnt: 12'd1, alast: 1'b1, default: '0};

	localparam int DIRECTED_COUNT = 25;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{'{KIND_OTHER_LO, 30'd0, 16'd0, 1'b1}, 1'b1, FAIL_SLICE},
		'{'{BIT_TRUE, 30'd0, 16'd0, 1'b1}, 1'b1, ONE_TRUE_SLICE},
		'{'{BIT_FALSE, 30'h3FFFFFFF, 16'hFFFF, 1'b1}, 1'b1, ONE_FALSE_SLICE},
		'{'{BIT_POS, 30'h3FFFFFFF, 16'hFFFF, 1'b1}, 1'b1, FAIL_SLICE},
		'{'{KIND_OTHER_HI, 30'h3FFFFFFF, 16'hFFFF, 1'b1}, 1'b1, FAIL_SLICE},
		'{'{BIT_NEG, 30'd0, 16'd0, 1'b1}, 1'b1, FAIL_SLICE},
		'{'{BIT_POS, 30'h3FFFFFFF, 16'hFFFE, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_POS, 30'h3FFFFFFF, 16'hFFFF, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_POS, 30'h3FFFFFFF, 16'h0000, 1'b1}, 1'b0, NO_SLICE},
		'{'{BIT_NEG, 30'd5, 16'd3, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_NEG, 30'd5, 16'd3, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_NEG, 30'd5, 16'd3, 1'b1}, 1'b0, NO_SLICE},
		'{'{BIT_NEG, 30'd9, 16'd0, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_POS, 30'd9, 16'd1, 1'b1}, 1'b0, NO_SLICE},
		'{'{BIT_FALSE, 30'h2AAAAAAA, 16'h5555, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_TRUE, 30'h15555555, 16'hAAAA, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_TRUE, 30'd0, 16'd0, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_POS, 30'd7, 16'h0010, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_POS, 30'd7, 16'h0010, 1'b1}, 1'b0, NO_SLICE},
		'{'{BIT_TRUE, 30'd1, 16'd1, 1'b0}, 1'b0, NO_SLICE},
		'{'{KIND_OTHER_LO, 30'd1, 16'd1, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_FALSE, 30'd1, 16'd1, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_TRUE, 30'd1, 16'd1, 1'b1}, 1'b0, NO_SLICE},
		'{'{BIT_POS, 30'd3, 16'd10, 1'b0}, 1'b0, NO_SLICE},
		'{'{BIT_POS, 30'd3, 16'd12, 1'b1}, 1'b0, NO_SLICE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        bit_valid = 1'b0;
	logic        bit_stall;
	logic [2:0]  bit_kind = '0;
	logic [29:0] vector_id = '0;
	logic [15:0] bit_index = '0;
	logic        last_bit = 1'b0;
	logic        slice_valid;
	logic        slice_stall = 1'b0;
	logic [1:0]  slice_kind;
	logic [1:0]  repeat_bit;
	logic [29:0] source_vector;
	logic [15:0] low_index;
	logic [15:0] high_index;
	logic [11:0] bit_count;
	logic [63:0] const_word;
	logic        word_last;
	logic        array_last;

	slicer_mode_t mode = M_IDLE;
	logic [2:0]   held_kind = '0;
	logic [29:0]  held_vec = '0;
	logic [15:0]  held_idx = '0;
	int unsigned  run_len = 0;
	logic [63:0]  word_store [32];
	bit           all_same = 1'b1;
	bit           first_const = 1'b0;
	int unsigned  bits_taken = 0;

	slice_t    item_slices [$];
	slice_t    pending_slices [$];
	bit_item_t array_bits [$];
	int        random_sent = 0;
	bit        steady = 1'b0;
	bit        mismatch_seen = 1'b0;
	int        cycle_count = 0;

	bit_array_run_slicer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.bit_valid(bit_valid),
		.bit_stall(bit_stall),
		.bit_kind(bit_kind),
		.vector_id(vector_id),
		.bit_index(bit_index),
		.last_bit(last_bit),
		.slice_valid(slice_valid),
		.slice_stall(slice_stall),
		.slice_kind(slice_kind),
		.repeat_bit(repeat_bit),
		.source_vector(source_vector),
		.low_index(low_index),
		.high_index(high_index),
		.bit_count(bit_count),
		.const_word(const_word),
		.word_last(word_last),
		.array_last(array_last)
	);

	always #6 clk = ~clk;

	task automatic push_slice(input logic [1:0] kind, input logic [1:0] rbit,
			input logic [29:0] vec, input logic [15:0] lo, input logic [15:0] hi,
			input logic [11:0] cnt, input logic [63:0] word, input logic wlast);
		slice_t s;
		s = '{kind, rbit, vec, lo, hi, cnt, word, wlast, 1'b0};
		item_slices.push_back(s);
	endtask

	task automatic clear_array();
		mode = M_IDLE;
		run_len = 0;
		bits_taken = 0;
	endtask

	task automatic add_const_bit(input bit value);
		int unsigned pos;
		logic [63:0] b;
		pos = run_len;
		b = 64'(value) << (pos % WORD_BITS);
		if (pos % WORD_BITS == 0)
			word_store[(pos / WORD_BITS) % 32] = b;
		else
			word_store[(pos / WORD_BITS) % 32] |= b;
		if (value != first_const)
			all_same = 1'b0;
		run_len = pos + 1;
	endtask

	task automatic close_const();
		int unsigned words;
		if (all_same) begin
			push_slice(SLICE_REPEAT, {1'b0, first_const}, '0, '0, '0, 12'(run_len), '0, 1'b0);
		end else begin
			words = (run_len + WORD_BITS - 1) / WORD_BITS;
			for (int unsigned w = 0; w < words && w < 32; w++)
				push_slice(SLICE_WORD, '0, '0, '0, '0, 12'(run_len), word_store[w],
					w + 1 == words);
		end
	endtask

	task automatic emit_held_run();
		if (mode == M_REPEAT)
			push_slice(SLICE_REPEAT, 2'(held_kind), held_vec, held_idx, '0, 12'(run_len), '0,
				1'b0);
		else
			push_slice(SLICE_EXTRACT, '0, held_vec, held_idx, 16'(held_idx + run_len - 1),
				'0, '0, 1'b0);
	endtask

	// Works out the slices that one accepted bit causes, into item_slices.
	task automatic predict_slices(input bit_item_t it);
		bit absorbed;
		bit failed;
		bit same;
		slice_t s;
		absorbed = 1'b0;
		failed = 1'b0;
		same = (it.kind == BIT_POS || it.kind == BIT_NEG) && it.kind == held_kind &&
			it.vec == held_vec && it.idx == held_idx;
		item_slices.delete();
		if (mode == M_DISCARD) begin
			if (it.last)
				clear_array();
		end else begin
			if (bits_taken >= MAX_BITS) begin
				failed = 1'b1;
			end else begin
				bits_taken++;
				case (mode)
					M_CONST: begin
						if (it.kind <= BIT_TRUE) begin
							add_const_bit(it.kind[0]);
							absorbed = 1'b1;
						end else begin
							close_const();
						end
					end
					M_PEND: begin
						if (same) begin
							mode = M_REPEAT;
							run_len = 2;
							absorbed = 1'b1;
						end else if (held_kind == BIT_POS && it.kind == BIT_POS &&
								it.vec == held_vec &&
								32'(it.idx) == 32'(held_idx) + 1) begin
							mode = M_EXTRACT;
							run_len = 2;
							absorbed = 1'b1;
						end else begin
							failed = 1'b1;
						end
					end
					M_REPEAT: begin
						if (same) begin
							run_len++;
							absorbed = 1'b1;
						end else begin
							emit_held_run();
						end
					end
					M_EXTRACT: begin
						if (it.kind == BIT_POS && it.vec == held_vec &&
								32'(it.idx) == 32'(held_idx) + run_len) begin
							run_len++;
							absorbed = 1'b1;
						end else begin
							emit_held_run();
						end
					end
					default: begin
					end
				endcase
				if (!failed && !absorbed) begin
					if (it.kind <= BIT_TRUE) begin
						mode = M_CONST;
						run_len = 0;
						all_same = 1'b1;
						first_const = it.kind[0];
						add_const_bit(it.kind[0]);
					end else if (it.kind <= BIT_NEG) begin
						mode = M_PEND;
						held_kind = it.kind;
						held_vec = it.vec;
						held_idx = it.idx;
						run_len = 1;
					end else begin
						failed = 1'b1;
					end
				end
				if (!failed && it.last) begin
					if (mode == M_CONST)
						close_const();
					else if (mode == M_PEND)
						failed = 1'b1;
					else if (mode == M_REPEAT || mode == M_EXTRACT)
						emit_held_run();
				end
			end
			if (failed) begin
				push_slice(SLICE_FAIL, '0, '0, '0, '0, '0, '0, 1'b0);
				if (it.last)
					clear_array();
				else
					mode = M_DISCARD;
			end else if (it.last) begin
				clear_array();
			end
			if ((failed || it.last) && item_slices.size() > 0) begin
				s = item_slices.pop_back();
				s.alast = 1'b1;
				item_slices.push_back(s);
			end
		end
	endtask

	task automatic send_bit(input bit_item_t it, input logic typed, input slice_t typed_res);
		while (!steady && $urandom_range(99) < 21) begin
			bit_valid <= 1'b0;
			@(posedge clk);
		end
		bit_valid <= 1'b1;
		bit_kind <= it.kind;
		vector_id <= it.vec;
		bit_index <= it.idx;
		last_bit <= it.last;
		@(posedge clk);
		while (bit_stall)
			@(posedge clk);
		predict_slices(it);
		if (typed)
			pending_slices.push_back(typed_res);
		else
			foreach (item_slices[i])
				pending_slices.push_back(item_slices[i]);
	endtask

	task automatic send_array(input bit counted);
		foreach (array_bits[i]) begin
			send_bit(array_bits[i], 1'b0, NO_SLICE);
			if (counted) begin
				random_sent++;
				steady <= random_sent >= 150 && random_sent < 260;
			end
		end
	endtask

	function automatic logic [29:0] pick_vector();
		case ($urandom_range(3))
			0: return 30'($urandom);
			1: return '0;
			2: return '1;
			default: return 30'($urandom_range(3));
		endcase
	endfunction

	task automatic build_random_array();
		int choice;
		int len;
		bit mixed;
		bit neg_start;
		logic [2:0] k;
		logic [29:0] v;
		logic [15:0] base;
		bit_item_t it;
		array_bits.delete();
		repeat ($urandom_range(1, 6)) begin
			choice = $urandom_range(99);
			v = pick_vector();
			it.last = 1'b0;
			if (choice < 38) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 20);
				mixed = $urandom_range(99) < 70;
				k = $urandom_range(1) ? BIT_TRUE : BIT_FALSE;
				repeat (len) begin
					it.kind = mixed ? ($urandom_range(1) ? BIT_TRUE : BIT_FALSE) : k;
					it.vec = 30'($urandom);
					it.idx = 16'($urandom);
					array_bits.push_back(it);
				end
			end else if (choice < 62) begin
				it.kind = $urandom_range(1) ? BIT_POS : BIT_NEG;
				it.vec = v;
				it.idx = 16'($urandom);
				len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 6);
				repeat (len)
					array_bits.push_back(it);
			end else if (choice < 93) begin
				base = ($urandom_range(3) == 0) ? 16'(65535 - $urandom_range(6)) :
					16'($urandom);
				len = $urandom_range(2, 8);
				neg_start = $urandom_range(7) == 0;
				for (int i = 0; i < len; i++) begin
					it.kind = (i == 0 && neg_start) ? BIT_NEG : BIT_POS;
					it.vec = v;
					it.idx = base + 16'(i);
					array_bits.push_back(it);
				end
			end else begin
				it.kind = 3'($urandom_range(KIND_OTHER_LO, KIND_OTHER_HI));
				it.vec = 30'($urandom);
				it.idx = 16'($urandom);
				array_bits.push_back(it);
			end
		end
		it = array_bits.pop_back();
		it.last = 1'b1;
		array_bits.push_back(it);
	endtask

	task automatic report_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			mismatch_seen = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		slice_t want;
		if (!arst_n) begin
			slice_stall <= 1'b0;
		end else begin
			if (slice_valid && !slice_stall) begin
				if (pending_slices.size() == 0) begin
					$display("%0t: unexpected item, kind %0d word %h, expected none", $time,
						slice_kind, const_word);
					mismatch_seen = 1'b1;
				end else begin
					want = pending_slices.pop_front();
					report_field("slice_kind", 64'(want.kind), 64'(slice_kind));
					report_field("repeat_bit", 64'(want.rbit), 64'(repeat_bit));
					report_field("source_vector", 64'(want.vec), 64'(source_vector));
					report_field("low_index", 64'(want.lo), 64'(low_index));
					report_field("high_index", 64'(want.hi), 64'(high_index));
					report_field("bit_count", 64'(want.cnt), 64'(bit_count));
					report_field("const_word", want.word, const_word);
					report_field("word_last", 64'(want.wlast), 64'(word_last));
					report_field("array_last", 64'(want.alast), 64'(array_last));
				end
			end
			slice_stall <= !steady && ($urandom_range(99) < 21);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		bit_item_t it;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r])
			send_bit(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);

		// A mixed constant of 2047 bits closed by a lone select: 32 words and a failure.
		array_bits.delete();
		it.last = 1'b0;
		for (int i = 0; i < 2047; i++) begin
			it.kind = (i == 0) ? BIT_FALSE : (i == 1) ? BIT_TRUE :
				($urandom_range(1) ? BIT_TRUE : BIT_FALSE);
			it.vec = 30'($urandom);
			it.idx = 16'($urandom);
			array_bits.push_back(it);
		end
		it.kind = BIT_POS;
		it.last = 1'b1;
		array_bits.push_back(it);
		send_array(1'b0);

		// An array that runs past the length limit.
		array_bits.delete();
		for (int i = 0; i < 2050; i++) begin
			it.kind = $urandom_range(1) ? BIT_TRUE : BIT_FALSE;
			it.vec = 30'($urandom);
			it.idx = 16'($urandom);
			it.last = i == 2049;
			array_bits.push_back(it);
		end
		send_array(1'b0);

		while (random_sent < RANDOM_ITEMS) begin
			build_random_array();
			send_array(1'b1);
		end

		bit_valid <= 1'b0;
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!mismatch_seen)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
